// ----- design/bpmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bpmfd_pkg
// Shared types and constants for the blood pressure monitor frame decoder.
// ----------------------------------------------------------------------------
package bpmfd_pkg;

  // Request kinds on the input channel.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_TAKEN = 2'd0;
  localparam logic [1:0] STATUS_FRAME = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam int unsigned POS_W = 5;
  localparam int unsigned PRESSURE_W = 10;
  localparam int unsigned TIMEOUT_W = 16;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [PRESSURE_W-1:0] pressure_t;

  // Frame positions with a meaning of their own.
  localparam pos_t POS_HDR0 = 5'd1;
  localparam pos_t POS_HDR1 = 5'd2;
  localparam pos_t POS_HDR2 = 5'd3;
  localparam pos_t POS_HDR3 = 5'd4;
  localparam pos_t POS_RD0 = 5'd12;
  localparam pos_t POS_RD1 = 5'd14;
  localparam pos_t POS_RD2 = 5'd16;
  localparam pos_t POS_RD3 = 5'd18;
  localparam pos_t FRAME_LEN = 5'd20;

  // Header pattern that marks a device error.
  localparam logic [7:0] ERR_HDR0 = 8'd10;
  localparam logic [7:0] ERR_HDR1 = 8'd11;
  localparam logic [7:0] ERR_HDR2 = 8'd2;
  localparam logic [7:0] ERR_HDR3 = 8'd3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd7000;
  localparam pressure_t PRESSURE_MAX = 10'd999;

endpackage

// ----- design/bpmfd_pressure.sv -----
// ----------------------------------------------------------------------------
// bpmfd_pressure
// Builds one pressure reading from a hundreds nibble and a byte that holds
// the tens and units nibbles, saturating at 999.
// ----------------------------------------------------------------------------
module bpmfd_pressure
  import bpmfd_pkg::*;
(
  input  logic [3:0] hundreds,
  input  logic [7:0] tens_units,
  output pressure_t  pressure
);

  logic [10:0] sum;

  // Nibbles above nine are taken at face value, so the sum can reach 1665.
  assign sum = ({7'd0, hundreds} * 11'd100)
             + ({7'd0, tens_units[7:4]} * 11'd10)
             + {7'd0, tens_units[3:0]};

  assign pressure = (sum > {1'b0, PRESSURE_MAX}) ? PRESSURE_MAX : sum[PRESSURE_W-1:0];

endmodule

// ----- design/bp_monitor_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// bp_monitor_frame_decoder
// Decodes the 20-byte frame of a blood pressure monitor from sniffed bytes
// and millisecond ticks.
// ----------------------------------------------------------------------------
// A byte or tick is decoded against the frame state in the cycle it is
// accepted, and a byte's result appears in the output register on the next
// cycle. One request per cycle is accepted as long as the output register
// is empty or being emptied; ticks give no result.
// The timeout register may be written at any time the block is idle and
// takes effect on the next byte. Frames restart after byte 20, after a device
// error header (10, 11, 2, 3), and when more than timeout_ms ticks passed
// since the previous byte.
module bp_monitor_frame_decoder
  import bpmfd_pkg::*;
#(
  parameter int unsigned IDLE_COUNTER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 timed_out,
  output pos_t                 byte_position,
  output pressure_t            systolic,
  output pressure_t            diastolic,
  output logic [7:0]           pulse
);

  localparam int unsigned CMP_W =
    (IDLE_COUNTER_WIDTH > TIMEOUT_W) ? IDLE_COUNTER_WIDTH : TIMEOUT_W;

  logic [TIMEOUT_W-1:0]          timeout_ms;
  pos_t                          byte_count;
  pos_t                          byte_count_next;
  logic [IDLE_COUNTER_WIDTH-1:0] idle_ms;
  logic [7:0]                    header_bytes [3];
  logic [7:0]                    reading_bytes [4];

  logic      in_fire;
  logic      byte_fire;
  logic      out_fire;
  logic      tmo;
  pos_t      pos;
  logic [1:0] status_next;
  logic      frame_done;
  pressure_t sys_value;
  pressure_t dia_value;

  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign byte_fire = in_fire && (req_type == REQ_BYTE);

  assign tmo = CMP_W'(idle_ms) > CMP_W'(timeout_ms);
  assign pos = (tmo ? '0 : byte_count) + 5'd1;

  always_comb begin
    status_next     = STATUS_TAKEN;
    byte_count_next = pos;
    unique case (pos)
      POS_HDR3: begin
        if (header_bytes[0] == ERR_HDR0 && header_bytes[1] == ERR_HDR1 &&
            header_bytes[2] == ERR_HDR2 && rx_byte == ERR_HDR3) begin
          status_next     = STATUS_ERROR;
          byte_count_next = '0;
        end
      end
      FRAME_LEN: begin
        status_next     = STATUS_FRAME;
        byte_count_next = '0;
      end
      default: begin
        if (pos > FRAME_LEN) begin
          byte_count_next = '0;
        end
      end
    endcase
  end

  assign frame_done = (status_next == STATUS_FRAME);

  bpmfd_pressure u_sys (
    .hundreds   (reading_bytes[0][7:4]),
    .tens_units (reading_bytes[1]),
    .pressure   (sys_value)
  );

  bpmfd_pressure u_dia (
    .hundreds   (reading_bytes[0][3:0]),
    .tens_units (reading_bytes[2]),
    .pressure   (dia_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      idle_ms    <= '0;
    end else if (in_fire) begin
      if (req_type == REQ_TICK) begin
        if (idle_ms != '1) begin
          idle_ms <= idle_ms + 1'b1;
        end
      end else begin
        idle_ms    <= '0;
        byte_count <= byte_count_next;
      end
    end
  end

  // Header and reading bytes are always written earlier in the same frame
  // than the position that reads them, so they need no reset.
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      case (pos)
        POS_HDR0: header_bytes[0] <= rx_byte;
        POS_HDR1: header_bytes[1] <= rx_byte;
        POS_HDR2: header_bytes[2] <= rx_byte;
        POS_RD0:  reading_bytes[0] <= rx_byte;
        POS_RD1:  reading_bytes[1] <= rx_byte;
        POS_RD2:  reading_bytes[2] <= rx_byte;
        POS_RD3:  reading_bytes[3] <= rx_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      status        <= status_next;
      timed_out     <= tmo;
      byte_position <= pos;
      systolic      <= frame_done ? sys_value : '0;
      diastolic     <= frame_done ? dia_value : '0;
      pulse         <= frame_done ? reading_bytes[3] : 8'd0;
    end
  end

`ifndef SYNTHESIS
  // A device error is only ever recognized on the fourth byte.
  a_error_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ERROR) |-> (byte_position == POS_HDR3))
    else $error("device error reported away from byte 4");

  // Readings are zero except on a completed frame.
  a_readings_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_FRAME) |->
      (systolic == '0 && diastolic == '0 && pulse == 8'd0))
    else $error("readings nonzero outside a completed frame");

  // Pressures saturate at 999.
  a_pressure_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (systolic <= PRESSURE_MAX && diastolic <= PRESSURE_MAX))
    else $error("pressure above saturation limit");

  // A byte clears the idle counter and always leaves a result behind.
  a_byte_effect: assert property (@(posedge clk) disable iff (rst)
    byte_fire |=> (out_valid && idle_ms == '0))
    else $error("accepted byte did not clear idle time or give a result");
`endif

endmodule

// ----- sim/tb_bp_monitor_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_bp_monitor_frame_decoder
// Self-checking bench for the blood pressure monitor frame decoder. Bytes and
// millisecond ticks are sent through the request channel while both sides
// stall at random. A frame tracker inside the bench predicts every result,
// and each result that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module tb_bp_monitor_frame_decoder;
  import bpmfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_W = 16;
  localparam int unsigned RANDOM_REQUESTS = 1500;

  typedef struct packed {
    logic [1:0] status;
    logic       timed_out;
    pos_t       pos;
    pressure_t  sys;
    pressure_t  dia;
    logic [7:0] pulse;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = REQ_BYTE;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic                 timed_out;
  pos_t                 byte_position;
  pressure_t            systolic;
  pressure_t            diastolic;
  logic [7:0]           pulse;

  // Frame tracker state.
  logic [TIMEOUT_W-1:0] tmo_limit;
  pos_t                 frame_count;
  logic [7:0]           hdr_q [3];
  logic [7:0]           rd_q [4];
  logic [IDLE_W-1:0]    idle_cnt;

  frame_result_t results_due[$];
  int unsigned   mismatch_count = 0;
  int unsigned   requests_accepted = 0;
  bit            steady_send = 1'b0;
  bit            steady_recv = 1'b0;

  bp_monitor_frame_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .timed_out     (timed_out),
    .byte_position (byte_position),
    .systolic      (systolic),
    .diastolic     (diastolic),
    .pulse         (pulse)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !steady_recv && ($urandom_range(0, 99) < 10);
  end

  function automatic pressure_t clamp_pressure(input int v);
    return (v > PRESSURE_MAX) ? PRESSURE_MAX : pressure_t'(v);
  endfunction

  // Advances the frame tracker by one accepted request and queues the
  // result that a byte produces.
  task automatic track_request(input logic kind, input logic [7:0] b);
    frame_result_t r;
    requests_accepted++;
    if (kind == REQ_TICK) begin
      if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
    end else begin
      r = '0;
      if (idle_cnt > tmo_limit) begin
        frame_count = '0;
        r.timed_out = 1'b1;
      end
      idle_cnt = '0;
      frame_count = frame_count + 1'b1;
      r.pos = frame_count;
      r.status = STATUS_TAKEN;
      case (frame_count)
        POS_HDR0: hdr_q[0] = b;
        POS_HDR1: hdr_q[1] = b;
        POS_HDR2: hdr_q[2] = b;
        POS_HDR3: begin
          if (hdr_q[0] == ERR_HDR0 && hdr_q[1] == ERR_HDR1 &&
              hdr_q[2] == ERR_HDR2 && b == ERR_HDR3) begin
            r.status = STATUS_ERROR;
            frame_count = '0;
          end
        end
        POS_RD0: rd_q[0] = b;
        POS_RD1: rd_q[1] = b;
        POS_RD2: rd_q[2] = b;
        POS_RD3: rd_q[3] = b;
        FRAME_LEN: begin
          r.status = STATUS_FRAME;
          r.sys = clamp_pressure(rd_q[0][7:4] * 100 + rd_q[1][7:4] * 10 + rd_q[1][3:0]);
          r.dia = clamp_pressure(rd_q[0][3:0] * 100 + rd_q[2][7:4] * 10 + rd_q[2][3:0]);
          r.pulse = rd_q[3];
          frame_count = '0;
        end
        default: ;
      endcase
      results_due.push_back(r);
    end
  endtask

  // Presents one request and returns at the edge where it is accepted.
  task automatic send_request(input logic kind, input logic [7:0] b);
    if (!steady_send && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    track_request(kind, b);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_request(REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Sends bytes until the frame restarts, with the readings given and the
  // fill byte everywhere else.
  task automatic send_frame(input logic [7:0] r0, input logic [7:0] r1,
                            input logic [7:0] r2, input logic [7:0] r3,
                            input logic [7:0] fill);
    pos_t       nxt;
    logic [7:0] b;
    do begin
      nxt = frame_count + 1'b1;
      case (nxt)
        POS_RD0: b = r0;
        POS_RD1: b = r1;
        POS_RD2: b = r2;
        POS_RD3: b = r3;
        default: b = fill;
      endcase
      send_request(REQ_BYTE, b);
    end while (frame_count != '0);
  endtask

  // Timeout changes only while nothing is in flight.
  task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tmo_limit = v;
  endtask

  function automatic logic [7:0] random_reading();
    if ($urandom_range(0, 1) == 0)
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_frame_byte(input pos_t p, input bit err_hdr,
                                                 input int unsigned bad_pos);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (err_hdr && p != bad_pos) begin
      case (p)
        POS_HDR0: b = ERR_HDR0;
        POS_HDR1: b = ERR_HDR1;
        POS_HDR2: b = ERR_HDR2;
        POS_HDR3: b = ERR_HDR3;
        default: ;
      endcase
    end
    if (p == POS_RD0 || p == POS_RD1 || p == POS_RD2 || p == POS_RD3)
      b = random_reading();
    return b;
  endfunction

  task automatic test_frame_decode();
    send_frame(8'h99, 8'h99, 8'h99, 8'hFF, 8'h00);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
  endtask

  task automatic test_device_error();
    send_request(REQ_BYTE, ERR_HDR0);
    send_request(REQ_BYTE, ERR_HDR1);
    send_request(REQ_BYTE, ERR_HDR2);
    send_request(REQ_BYTE, ERR_HDR3);
    // Last header byte off by one: the frame carries on to the end.
    send_request(REQ_BYTE, ERR_HDR0);
    send_request(REQ_BYTE, ERR_HDR1);
    send_request(REQ_BYTE, ERR_HDR2);
    send_request(REQ_BYTE, ERR_HDR3 + 8'd1);
    send_frame(8'h12, 8'h34, 8'h56, 8'd72, 8'h5A);
    // The pattern one position late is not a header.
    send_request(REQ_BYTE, 8'h00);
    send_request(REQ_BYTE, ERR_HDR0);
    send_request(REQ_BYTE, ERR_HDR1);
    send_request(REQ_BYTE, ERR_HDR2);
    send_request(REQ_BYTE, ERR_HDR3);
    send_frame(8'h01, 8'h02, 8'h03, 8'h04, 8'hA5);
  endtask

  task automatic test_nonbcd_readings();
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h3C);
    send_frame(8'hA0, 8'h0F, 8'hF0, 8'h01, 8'hC3);
    send_frame(8'h9A, 8'h9A, 8'h99, 8'h7F, 8'h0A);
  endtask

  task automatic test_timeout_default();
    send_request(REQ_BYTE, 8'h55);
    // Well under the reset limit, so the frame carries on.
    send_ticks(60);
    send_request(REQ_BYTE, 8'hAA);
    send_request(REQ_BYTE, 8'h0F);
    send_frame(8'h21, 8'h43, 8'h65, 8'd60, 8'h11);
  endtask

  task automatic test_timeout_extremes();
    write_timeout('0);
    send_request(REQ_BYTE, 8'h01);
    send_request(REQ_BYTE, 8'h02);
    send_ticks(1);
    send_request(REQ_BYTE, 8'h03);
    // Exactly at the limit the frame survives; one tick more drops it.
    write_timeout(16'd5);
    send_request(REQ_BYTE, 8'h04);
    send_ticks(5);
    send_request(REQ_BYTE, 8'h05);
    send_ticks(6);
    send_request(REQ_BYTE, 8'h06);
    write_timeout(16'hFFFF);
    send_ticks(40);
    send_request(REQ_BYTE, 8'h07);
    send_frame(8'h88, 8'h77, 8'h66, 8'hEE, 8'h99);
  endtask

  task automatic test_random_traffic();
    logic [TIMEOUT_W-1:0] limits [5];
    int unsigned phase_end;
    int unsigned span;
    int unsigned k;
    int unsigned bad_pos;
    bit          err_hdr;
    limits[0] = 16'd3;
    limits[1] = 16'd0;
    limits[2] = 16'd25;
    limits[3] = 16'($urandom_range(8, 40));
    limits[4] = 16'hFFFF;
    for (int ph = 0; ph < 5; ph++) begin
      write_timeout(limits[ph]);
      span = (limits[ph] > 248) ? 40 : limits[ph] + 2;
      steady_send = (ph == 2);
      steady_recv = (ph == 2);
      phase_end = requests_accepted + RANDOM_REQUESTS / 5;
      while (requests_accepted < phase_end) begin
        k = $urandom_range(0, 99);
        if (k < 80) begin
          // Well-formed frame, or a device error header, possibly spoiled.
          err_hdr = (k >= 62);
          bad_pos = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
          do begin
            if ($urandom_range(0, 99) < 4) send_ticks($urandom_range(0, span));
            send_request(REQ_BYTE,
                         pick_frame_byte(frame_count + 1'b1, err_hdr, bad_pos));
          end while (frame_count != '0);
        end else if (k < 92) begin
          repeat ($urandom_range(1, 19)) begin
            if ($urandom_range(0, 99) < 10) send_ticks($urandom_range(0, span));
            send_request(REQ_BYTE, 8'($urandom_range(0, 255)));
          end
        end else begin
          repeat ($urandom_range(1, 8))
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result with none expected: byte_position %0d", byte_position);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (timed_out !== want.timed_out) begin
          $error("timed_out: expected %0d, got %0d", want.timed_out, timed_out);
          mismatch_count++;
        end
        if (byte_position !== want.pos) begin
          $error("byte_position: expected %0d, got %0d", want.pos, byte_position);
          mismatch_count++;
        end
        if (systolic !== want.sys) begin
          $error("systolic: expected %0d, got %0d", want.sys, systolic);
          mismatch_count++;
        end
        if (diastolic !== want.dia) begin
          $error("diastolic: expected %0d, got %0d", want.dia, diastolic);
          mismatch_count++;
        end
        if (pulse !== want.pulse) begin
          $error("pulse: expected %0d, got %0d", want.pulse, pulse);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    tmo_limit = TIMEOUT_RESET;
    frame_count = '0;
    idle_cnt = '0;
    for (int i = 0; i < 3; i++) hdr_q[i] = '0;
    for (int i = 0; i < 4; i++) rd_q[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_frame_decode();
    test_device_error();
    test_nonbcd_readings();
    test_timeout_default();
    test_timeout_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bpmfd_pkg.sv
design/bpmfd_pressure.sv
design/bp_monitor_frame_decoder.sv
sim/tb_bp_monitor_frame_decoder.sv
